>>> hdl/lome_pkg.sv
// package for the limit order matching engine
// shared widths, payload structs and status codes; no dependencies
package lome_pkg;
    localparam int ORDERS_PER_SIDE = 32;
    localparam int IDX_W = $clog2(ORDERS_PER_SIDE);
    localparam int CNT_W = $clog2(ORDERS_PER_SIDE + 1);
    localparam int ID_W = 32;
    localparam int PRICE_W = 20;
    localparam int QTY_W = 24;
    localparam int ENTRY_W = ID_W + PRICE_W + QTY_W;

    localparam logic [1:0] STATUS_FILLED = 2'd0;
    localparam logic [1:0] STATUS_RESTED = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;
    localparam logic KIND_TRADE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0] order_id;
        logic side;
        logic [PRICE_W-1:0] limit_price;
        logic [QTY_W-1:0] order_quantity;
    } order_t;

    typedef struct packed {
        logic kind;
        logic [ID_W-1:0] buyer_id;
        logic [ID_W-1:0] seller_id;
        logic [PRICE_W-1:0] trade_price;
        logic [QTY_W-1:0] amount;
        logic [1:0] status;
        logic last;
    } result_t;
endpackage

>>> hdl/lome_if.sv
// valid/ready channel interfaces for orders and results
// depends on lome_pkg
interface lome_order_if;
    logic valid;
    logic ready;
    lome_pkg::order_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lome_result_if;
    logic valid;
    logic ready;
    lome_pkg::result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/lome_ram.sv
// generic single write port ram with registered read
// no dependencies
module lome_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hdl/limit_order_matching_engine_top.sv
// limit order matching engine: an order that neither trades nor rests gets a match read
// and compare, then its done item; a fill adds read, compare and emit steps, plus a read
// and write per entry shifted down when the head empties; resting adds a read and compare
// per entry scanned and a read and write per entry moved up. a stalled result holds the
// loop. one order at a time; ready is low until the done item is taken. rst_n clears both
// book counts; entries undefined until written. depends on lome_pkg, lome_if and lome_ram
module limit_order_matching_engine_top (
    input logic clk,
    input logic rst_n,
    lome_order_if.sink orders,
    lome_result_if.source results
);
    localparam int IW = lome_pkg::IDX_W;
    localparam int CW = lome_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MREAD, S_MCHK, S_EMIT, S_SHREAD, S_SHWR,
        S_FIND, S_FCHK, S_MOVE, S_MOVEWR, S_DONE, S_WAIT
    } state_t;

    state_t state_reg;
    lome_pkg::order_t ord_reg;
    logic [CW-1:0] cnt_reg [2];
    logic [CW-1:0] ptr_reg;
    logic [lome_pkg::QTY_W-1:0] fill_reg;
    logic [1:0] status_reg;
    logic out_valid_reg;
    lome_pkg::result_t out_reg;

    // bank 0 holds bids, bank 1 asks; one ram per side
    logic we [2];
    logic [IW-1:0] waddr, raddr;
    logic [lome_pkg::ENTRY_W-1:0] wdata;
    logic [lome_pkg::ENTRY_W-1:0] rdata [2];

    logic sell, opp, oside;
    assign sell = ord_reg.side;
    assign opp = ~sell;
    assign oside = sell;

    for (genvar s = 0; s < 2; s++)
    begin : g_side
        lome_ram #(.WIDTH(lome_pkg::ENTRY_W), .DEPTH(lome_pkg::ORDERS_PER_SIDE)) u_ram (
            .clk(clk), .we(we[s]), .waddr(waddr), .wdata(wdata),
            .raddr(raddr), .rdata(rdata[s])
        );
    end

    logic [lome_pkg::ENTRY_W-1:0] opp_data, own_data;
    logic [lome_pkg::ID_W-1:0] r_id;
    logic [lome_pkg::PRICE_W-1:0] r_price;
    logic [lome_pkg::QTY_W-1:0] r_qty, fill;
    logic crosses, behind;
    assign opp_data = opp ? rdata[1] : rdata[0];
    assign own_data = oside ? rdata[1] : rdata[0];
    assign {r_id, r_price, r_qty} = opp_data;
    assign crosses = sell ? (r_price >= ord_reg.limit_price)
                          : (r_price <= ord_reg.limit_price);
    assign fill = (ord_reg.order_quantity < r_qty) ? ord_reg.order_quantity : r_qty;
    logic [lome_pkg::PRICE_W-1:0] own_price;
    assign own_price = own_data[lome_pkg::QTY_W +: lome_pkg::PRICE_W];
    assign behind = sell ? (own_price <= ord_reg.limit_price)
                         : (own_price >= ord_reg.limit_price);

    function automatic logic [lome_pkg::QTY_W-1:0] QTY_EXT(input logic [CW-1:0] v);
        QTY_EXT = lome_pkg::QTY_W'(v);
    endfunction

    // ram port control
    always_comb
    begin
        we[0] = 1'b0;
        we[1] = 1'b0;
        waddr = ptr_reg[IW-1:0];
        wdata = own_data;
        raddr = ptr_reg[IW-1:0];
        case (state_reg)
            S_MCHK:
            begin
                // partial fill of the head: write back reduced size
                if (cnt_reg[opp] != '0 && crosses && ord_reg.order_quantity != '0
                    && fill != r_qty)
                begin
                    we[opp] = 1'b1;
                    waddr = '0;
                    wdata = {r_id, r_price, r_qty - fill};
                end
            end
            S_SHWR:
            begin
                we[opp] = 1'b1;
                waddr = IW'(ptr_reg - CW'(1));
                wdata = opp_data;
            end
            S_MOVEWR:
            begin
                we[oside] = 1'b1;
                waddr = ptr_reg[IW-1:0];
                wdata = own_data;
            end
            S_DONE:
            begin
                if (status_reg == lome_pkg::STATUS_RESTED)
                begin
                    we[oside] = 1'b1;
                    waddr = ptr_reg[IW-1:0];
                    wdata = {ord_reg.order_id, ord_reg.limit_price, ord_reg.order_quantity};
                end
            end
            S_MOVE:
            begin
                raddr = IW'(ptr_reg - CW'(1));
            end
            default:
            begin
            end
        endcase
    end

    assign orders.ready = (state_reg == S_IDLE);
    assign results.valid = out_valid_reg;
    assign results.payload = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            out_valid_reg <= 1'b0;
            ptr_reg <= '0;
            status_reg <= lome_pkg::STATUS_FILLED;
        end
        else
        begin
            if (out_valid_reg && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (orders.valid)
                    begin
                        ord_reg <= orders.payload;
                        ptr_reg <= '0;
                        state_reg <= S_MREAD;
                    end
                end
                S_MREAD:
                begin
                    // hold until the previous item has left the output register
                    ptr_reg <= '0;
                    if (!out_valid_reg || results.ready)
                    begin
                        state_reg <= S_MCHK;
                    end
                end
                S_MCHK:
                begin
                    if (cnt_reg[opp] != '0 && crosses && ord_reg.order_quantity != '0)
                    begin
                        fill_reg <= fill;
                        ord_reg.order_quantity <= ord_reg.order_quantity - fill;
                        out_reg <= '{kind: lome_pkg::KIND_TRADE,
                            buyer_id: sell ? r_id : ord_reg.order_id,
                            seller_id: sell ? ord_reg.order_id : r_id,
                            trade_price: r_price, amount: fill,
                            status: lome_pkg::STATUS_FILLED, last: 1'b0};
                        if (fill == r_qty)
                        begin
                            // head emptied: shift remaining entries down
                            ptr_reg <= CW'(1);
                            state_reg <= S_SHREAD;
                        end
                        else
                        begin
                            ptr_reg <= '0;
                            state_reg <= S_EMIT;
                        end
                    end
                    else
                    begin
                        ptr_reg <= '0;
                        if (ord_reg.order_quantity == '0)
                        begin
                            status_reg <= lome_pkg::STATUS_FILLED;
                            state_reg <= S_DONE;
                        end
                        else if (cnt_reg[oside] >= CW'(lome_pkg::ORDERS_PER_SIDE))
                        begin
                            status_reg <= lome_pkg::STATUS_DROPPED;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            status_reg <= lome_pkg::STATUS_RESTED;
                            state_reg <= S_FIND;
                        end
                    end
                end
                S_SHREAD:
                begin
                    if (ptr_reg >= cnt_reg[opp])
                    begin
                        cnt_reg[opp] <= cnt_reg[opp] - CW'(1);
                        ptr_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_SHWR;
                    end
                end
                S_SHWR:
                begin
                    ptr_reg <= ptr_reg + CW'(1);
                    state_reg <= S_SHREAD;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        ptr_reg <= '0;
                        state_reg <= S_MREAD;
                    end
                end
                S_FIND:
                begin
                    state_reg <= S_FCHK;
                end
                S_FCHK:
                begin
                    if (ptr_reg < cnt_reg[oside] && behind)
                    begin
                        ptr_reg <= ptr_reg + CW'(1);
                        state_reg <= S_FIND;
                    end
                    else
                    begin
                        // ptr holds insert point; move tail up from count
                        fill_reg <= QTY_EXT(ptr_reg);
                        ptr_reg <= cnt_reg[oside];
                        state_reg <= S_MOVE;
                    end
                end
                S_MOVE:
                begin
                    if (ptr_reg == fill_reg[CW-1:0])
                    begin
                        cnt_reg[oside] <= cnt_reg[oside] + CW'(1);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_MOVEWR;
                    end
                end
                S_MOVEWR:
                begin
                    ptr_reg <= ptr_reg - CW'(1);
                    state_reg <= S_MOVE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg <= '{kind: lome_pkg::KIND_DONE,
                            buyer_id: ord_reg.order_id, seller_id: '0,
                            trade_price: '0, amount: ord_reg.order_quantity,
                            status: status_reg, last: 1'b1};
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (!out_valid_reg || results.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !orders.ready)
        else $error("order accepted while busy");
    ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[0] <= CW'(lome_pkg::ORDERS_PER_SIDE))
        && (cnt_reg[1] <= CW'(lome_pkg::ORDERS_PER_SIDE)))
        else $error("book count above capacity");
    ap_trade_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.payload.kind == lome_pkg::KIND_TRADE)
        |-> (results.payload.amount != '0))
        else $error("trade of zero quantity");
endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// testbench for the limit order matching engine: drives orders, predicts
// trade and done items with a local order book, checks each result in order
// depends on lome_pkg, lome_if and limit_order_matching_engine_top
module tb_top;
    localparam int NUM_RANDOM = 330;
    localparam int NUM_DIRECTED = 12;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lome_order_if orders();
    lome_result_if results();

    limit_order_matching_engine_top u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .orders(orders.sink),
        .results(results.source)
    );

    always #5 clk = ~clk;

    // local book, index 0 is best
    logic [lome_pkg::ID_W-1:0] bid_id_q[$];
    logic [lome_pkg::PRICE_W-1:0] bid_px_q[$];
    logic [lome_pkg::QTY_W-1:0] bid_sz_q[$];
    logic [lome_pkg::ID_W-1:0] ask_id_q[$];
    logic [lome_pkg::PRICE_W-1:0] ask_px_q[$];
    logic [lome_pkg::QTY_W-1:0] ask_sz_q[$];

    lome_pkg::result_t expected_fills[$];
    int err_count = 0;
    bit sending_done = 1'b0;

    // directed rows: id, side, price, qty; done status typed where obvious
    lome_pkg::order_t dir_orders[NUM_DIRECTED];
    int dir_status[NUM_DIRECTED];

    function automatic void add_expected(input lome_pkg::result_t r);
        expected_fills.insert(expected_fills.size(), r);
    endfunction

    function automatic void match_order(input lome_pkg::order_t o);
        lome_pkg::result_t r;
        logic [lome_pkg::QTY_W-1:0] qty;
        logic [lome_pkg::QTY_W-1:0] fill;
        int pos;
        qty = o.order_quantity;
        if (o.side == 1'b0)
        begin
            while (qty != 0 && ask_id_q.size() > 0 && ask_px_q[0] <= o.limit_price)
            begin
                fill = (qty < ask_sz_q[0]) ? qty : ask_sz_q[0];
                r = '0;
                r.kind = lome_pkg::KIND_TRADE;
                r.buyer_id = o.order_id;
                r.seller_id = ask_id_q[0];
                r.trade_price = ask_px_q[0];
                r.amount = fill;
                add_expected(r);
                qty -= fill;
                ask_sz_q[0] -= fill;
                if (ask_sz_q[0] == 0)
                begin
                    void'(ask_id_q.pop_front());
                    void'(ask_px_q.pop_front());
                    void'(ask_sz_q.pop_front());
                end
            end
        end
        else
        begin
            while (qty != 0 && bid_id_q.size() > 0 && bid_px_q[0] >= o.limit_price)
            begin
                fill = (qty < bid_sz_q[0]) ? qty : bid_sz_q[0];
                r = '0;
                r.kind = lome_pkg::KIND_TRADE;
                r.buyer_id = bid_id_q[0];
                r.seller_id = o.order_id;
                r.trade_price = bid_px_q[0];
                r.amount = fill;
                add_expected(r);
                qty -= fill;
                bid_sz_q[0] -= fill;
                if (bid_sz_q[0] == 0)
                begin
                    void'(bid_id_q.pop_front());
                    void'(bid_px_q.pop_front());
                    void'(bid_sz_q.pop_front());
                end
            end
        end
        r = '0;
        r.kind = lome_pkg::KIND_DONE;
        r.buyer_id = o.order_id;
        r.amount = qty;
        r.last = 1'b1;
        if (qty == 0)
            r.status = lome_pkg::STATUS_FILLED;
        else if (o.side == 1'b0)
        begin
            if (bid_id_q.size() >= lome_pkg::ORDERS_PER_SIDE)
                r.status = lome_pkg::STATUS_DROPPED;
            else
            begin
                pos = 0;
                while (pos < bid_id_q.size() && bid_px_q[pos] >= o.limit_price)
                    pos++;
                bid_id_q.insert(pos, o.order_id);
                bid_px_q.insert(pos, o.limit_price);
                bid_sz_q.insert(pos, qty);
                r.status = lome_pkg::STATUS_RESTED;
            end
        end
        else
        begin
            if (ask_id_q.size() >= lome_pkg::ORDERS_PER_SIDE)
                r.status = lome_pkg::STATUS_DROPPED;
            else
            begin
                pos = 0;
                while (pos < ask_id_q.size() && ask_px_q[pos] <= o.limit_price)
                    pos++;
                ask_id_q.insert(pos, o.order_id);
                ask_px_q.insert(pos, o.limit_price);
                ask_sz_q.insert(pos, qty);
                r.status = lome_pkg::STATUS_RESTED;
            end
        end
        add_expected(r);
    endfunction

    task automatic send_order(input lome_pkg::order_t o, input int want_status);
        int gap;
        if ($urandom_range(0, 3) == 0)
        begin
            orders.valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        orders.valid <= 1'b1;
        orders.payload <= o;
        @(posedge clk);
        while (!orders.ready)
            @(posedge clk);
        match_order(o);
        if (want_status >= 0 && expected_fills[$].status != want_status[1:0])
        begin
            $error("status: table %0d, predicted %0d", want_status,
                expected_fills[$].status);
            err_count++;
        end
        @(negedge clk);
    endtask

    function automatic lome_pkg::order_t random_order(input int n);
        lome_pkg::order_t o;
        int mode;
        o.order_id = $urandom;
        o.side = 1'($urandom_range(0, 1));
        mode = $urandom_range(0, 19);
        // prices mostly near a mid so the books cross often
        if (mode == 0)
            o.limit_price = lome_pkg::PRICE_W'($urandom);
        else
            o.limit_price = lome_pkg::PRICE_W'(500000 + $urandom_range(0, 40) - 20);
        if (mode == 1)
            o.order_quantity = '0;
        else if (mode == 2)
            o.order_quantity = lome_pkg::QTY_W'($urandom);
        else if (mode < 6)
            o.order_quantity = lome_pkg::QTY_W'($urandom_range(1, 8));
        else
            o.order_quantity = lome_pkg::QTY_W'($urandom_range(1, 2000));
        // one phase fills each side in turn up to drop orders
        if (n >= 100 && n < 170)
        begin
            o.side = (n < 135) ? 1'b0 : 1'b1;
            o.limit_price = (n < 135) ? 20'd1000 : 20'd1040000;
        end
        return o;
    endfunction

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
            results.ready <= 1'b0;
        else
            results.ready <= ($urandom_range(0, 9) < 7) || sending_done;
    end

    always @(posedge clk)
    begin
        lome_pkg::result_t a;
        lome_pkg::result_t e;
        if (rst_n && results.valid && results.ready)
        begin
            a = results.payload;
            if (expected_fills.size() == 0)
            begin
                $error("unexpected result item kind %0d", a.kind);
                err_count++;
            end
            else
            begin
                e = expected_fills.pop_front();
                if (a.kind !== e.kind)
                begin
                    $error("kind: expected %0d, actual %0d", e.kind, a.kind);
                    err_count++;
                end
                if (a.buyer_id !== e.buyer_id)
                begin
                    $error("buyer_id: expected %0h, actual %0h", e.buyer_id, a.buyer_id);
                    err_count++;
                end
                if (a.seller_id !== e.seller_id)
                begin
                    $error("seller_id: expected %0h, actual %0h", e.seller_id, a.seller_id);
                    err_count++;
                end
                if (a.trade_price !== e.trade_price)
                begin
                    $error("trade_price: expected %0d, actual %0d", e.trade_price,
                        a.trade_price);
                    err_count++;
                end
                if (a.amount !== e.amount)
                begin
                    $error("amount: expected %0d, actual %0d", e.amount, a.amount);
                    err_count++;
                end
                if (a.status !== e.status)
                begin
                    $error("status: expected %0d, actual %0d", e.status, a.status);
                    err_count++;
                end
                if (a.last !== e.last)
                begin
                    $error("last: expected %0d, actual %0d", e.last, a.last);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        int burst;
        int k;
        orders.valid = 1'b0;
        orders.payload = '0;
        // id, side, price, qty
        dir_orders[0] = {32'h0000_0000, 1'b0, 20'd0, 24'd0};
        dir_orders[1] = {32'hFFFF_FFFF, 1'b1, 20'hFFFFF, 24'd5};
        dir_orders[2] = {32'h0000_0001, 1'b0, 20'd10, 24'hFFFFFF};
        dir_orders[3] = {32'hAAAA_5555, 1'b0, 20'd10, 24'd7};
        dir_orders[4] = {32'h5555_AAAA, 1'b1, 20'd0, 24'd3};
        dir_orders[5] = {32'h0000_0002, 1'b1, 20'd5, 24'hFFFFFF};
        dir_orders[6] = {32'h0000_0003, 1'b0, 20'hFFFFF, 24'd100};
        dir_orders[7] = {32'h0000_0004, 1'b1, 20'hFFFFF, 24'd0};
        dir_orders[8] = {32'h0000_0004, 1'b1, 20'd20, 24'd9};
        dir_orders[9] = {32'h0000_0004, 1'b1, 20'd20, 24'd9};
        dir_orders[10] = {32'h0000_0005, 1'b0, 20'hFFFFF, 24'hFFFFFF};
        dir_orders[11] = {32'h8000_0000, 1'b1, 20'd0, 24'h800000};
        dir_status[0] = int'(lome_pkg::STATUS_FILLED);
        dir_status[1] = int'(lome_pkg::STATUS_RESTED);
        dir_status[2] = int'(lome_pkg::STATUS_RESTED);
        dir_status[3] = -1;
        dir_status[4] = -1;
        dir_status[5] = -1;
        dir_status[6] = -1;
        dir_status[7] = int'(lome_pkg::STATUS_FILLED);
        dir_status[8] = -1;
        dir_status[9] = -1;
        dir_status[10] = -1;
        dir_status[11] = -1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (k = 0; k < NUM_DIRECTED; k++)
            send_order(dir_orders[k], dir_status[k]);
        k = 0;
        while (k < NUM_RANDOM)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                if (k < NUM_RANDOM)
                    send_order(random_order(k), -1);
                k++;
            end
            orders.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        orders.valid <= 1'b0;
        sending_done = 1'b1;
        while (expected_fills.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("tb_top: errors");
        $finish;
    end
endmodule
